>>> src/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Shared constants for the positional list engine: operation codes, status
// codes, field widths and the default list capacity.
// ----------------------------------------------------------------------------
package plist_pkg;

  // Default number of list entries.
  localparam int unsigned DEFAULT_CAPACITY = 256;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned FPOS_W  = 8;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned STAT_W  = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

>>> src/plist_ram.sv
// ----------------------------------------------------------------------------
// plist_ram
// Generic simple dual-port RAM: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module plist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values held densely in a RAM, with read,
// write, insert, remove and search at a list position.
// ----------------------------------------------------------------------------
// One request transaction is taken at a time and gives exactly one result
// transaction. The list lives in a single RAM with one write and one read
// port; a small sequencer walks it one entry per cycle, with the registered
// read data written back or compared in the cycle after the read. A write,
// or any request that fails its position or capacity check, goes straight
// from decode to the result stage; a read fetches its single entry, an
// insert or remove at position p walks the entries from p to the end of the
// list, and a search walks from the start until its first hit or the end.
// The input stays stalled while a request is in progress, but a finished
// result waits in the output register without blocking the next request.
// The RAM contents need no initialization: only entries below the current
// count are ever read.
module positional_list_engine
  import plist_pkg::*;
#(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_op,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [VAL_W-1:0]  in_value,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_read_value,
  output logic [FPOS_W-1:0]        out_found_position,
  output logic [LEN_W-1:0]         out_length,
  output logic [STAT_W-1:0]        out_status
);

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [31:0] CAP_32 = 32'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOP,
    S_RESP
  } state_t;

  // Sequencer and list state.
  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [OP_W-1:0]           op_r, op_nxt;
  logic [CNT_W-1:0]          pos_r, pos_nxt;
  logic signed [VAL_W-1:0]   val_r, val_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic                      pend_r, pend_nxt;
  logic [CNT_W-1:0]          pend_idx_r, pend_idx_nxt;

  // Result being built, then the output register.
  logic signed [VAL_W-1:0]   res_rval_r, res_rval_nxt;
  logic [FPOS_W-1:0]         res_fpos_r, res_fpos_nxt;
  logic [STAT_W-1:0]         res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0]   out_rval_r, out_rval_nxt;
  logic [FPOS_W-1:0]         out_fpos_r, out_fpos_nxt;
  logic [LEN_W-1:0]          out_len_r, out_len_nxt;
  logic [STAT_W-1:0]         out_status_r, out_status_nxt;

  // RAM ports.
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [VAL_W-1:0]          ram_wdata;
  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [VAL_W-1:0]          ram_rdata;

  // Helper values.
  logic [31:0]               in_pos_32;
  logic [31:0]               cnt_32;
  logic [31:0]               pend_idx_32;
  logic [CNT_W-1:0]          pend_up;
  logic [CNT_W-1:0]          pend_dn;
  logic                      in_fire;
  logic                      out_free;
  logic                      match;

  plist_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_pos_32   = 32'(in_position);
  assign cnt_32      = 32'(cnt_r);
  assign pend_idx_32 = 32'(pend_idx_r);
  assign pend_up     = pend_idx_r + CNT_W'(1);
  assign pend_dn     = pend_idx_r - CNT_W'(1);
  assign in_fire     = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign match       = pend_r && (op_r == OP_SEARCH) && (ram_rdata == val_r);

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_read_value     = out_rval_r;
  assign out_found_position = out_fpos_r;
  assign out_length         = out_len_r;
  assign out_status         = out_status_r;

  // Sequencer: request decode, list walk and result hand-off.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_rval_nxt   = res_rval_r;
    res_fpos_nxt   = res_fpos_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_rval_nxt   = out_rval_r;
    out_fpos_nxt   = out_fpos_r;
    out_len_nxt    = out_len_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r[ADDR_W-1:0];
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_op;
          pos_nxt        = in_pos_32[CNT_W-1:0];
          val_nxt        = in_value;
          pend_nxt       = 1'b0;
          res_rval_nxt   = '0;
          res_fpos_nxt   = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
          case (in_op)
            OP_READ: begin
              if (in_pos_32 < cnt_32) begin
                idx_nxt   = in_pos_32[CNT_W-1:0];
                rem_nxt   = CNT_W'(1);
                state_nxt = S_LOOP;
              end else begin
                res_status_nxt = ST_BADPOS;
              end
            end
            OP_WRITE: begin
              if (in_pos_32 < cnt_32) begin
                ram_we    = 1'b1;
                ram_waddr = in_pos_32[ADDR_W-1:0];
                ram_wdata = in_value;
              end else begin
                res_status_nxt = ST_BADPOS;
              end
            end
            OP_INSERT: begin
              if (in_pos_32 > cnt_32) begin
                res_status_nxt = ST_BADPOS;
              end else if (cnt_32 >= CAP_32) begin
                res_status_nxt = ST_FULL;
              end else begin
                // Move entries up, walking from the top down to the position.
                idx_nxt   = cnt_r - CNT_W'(1);
                rem_nxt   = cnt_r - in_pos_32[CNT_W-1:0];
                state_nxt = S_LOOP;
              end
            end
            OP_REMOVE: begin
              if (in_pos_32 < cnt_32) begin
                // Read the removed entry first, then move later ones down.
                idx_nxt   = in_pos_32[CNT_W-1:0];
                rem_nxt   = cnt_r - in_pos_32[CNT_W-1:0];
                state_nxt = S_LOOP;
              end else begin
                res_status_nxt = ST_BADPOS;
              end
            end
            OP_SEARCH: begin
              idx_nxt   = '0;
              rem_nxt   = cnt_r;
              state_nxt = S_LOOP;
            end
            default: begin
            end
          endcase
        end
      end

      S_LOOP: begin
        // Handle the data read in the previous cycle.
        if (pend_r) begin
          case (op_r)
            OP_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = pend_up[ADDR_W-1:0];
              ram_wdata = ram_rdata;
            end
            OP_REMOVE: begin
              if (pend_idx_r == pos_r) begin
                res_rval_nxt = ram_rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pend_dn[ADDR_W-1:0];
                ram_wdata = ram_rdata;
              end
            end
            OP_READ: begin
              res_rval_nxt = ram_rdata;
            end
            default: begin
            end
          endcase
        end

        // Issue the next read of the walk.
        if (rem_r != '0) begin
          ram_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          rem_nxt      = rem_r - CNT_W'(1);
          idx_nxt      = (op_r == OP_INSERT) ? (idx_r - CNT_W'(1))
                                             : (idx_r + CNT_W'(1));
        end else begin
          pend_nxt = 1'b0;
        end

        // Finish on the first search hit, or once the walk has drained.
        if (match) begin
          res_fpos_nxt   = pend_idx_32[FPOS_W-1:0];
          res_status_nxt = ST_OK;
          pend_nxt       = 1'b0;
          state_nxt      = S_RESP;
        end else if (rem_r == '0 && !pend_r) begin
          state_nxt = S_RESP;
          case (op_r)
            OP_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = pos_r[ADDR_W-1:0];
              ram_wdata = val_r;
              cnt_nxt   = cnt_r + CNT_W'(1);
            end
            OP_REMOVE: begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
            OP_SEARCH: begin
              res_status_nxt = ST_NOTFOUND;
            end
            default: begin
            end
          endcase
        end
      end

      S_RESP: begin
        // Move the result into the output register once it is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_rval_nxt   = res_rval_r;
          out_fpos_nxt   = res_fpos_r;
          out_len_nxt    = cnt_32[LEN_W-1:0];
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_rval_r   <= res_rval_nxt;
    res_fpos_r   <= res_fpos_nxt;
    res_status_r <= res_status_nxt;
    out_rval_r   <= out_rval_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_len_r    <= out_len_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  // The entry count never exceeds the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_32 <= CAP_32)
    else $error("list count exceeds capacity");

  // A full status is only reported when the list holds CAPACITY entries.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_len_r == CAP_32[LEN_W-1:0]))
    else $error("full status with a list that is not full");

  // Every RAM write lands inside the list capacity.
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_waddr) < CAP_32))
    else $error("RAM write beyond capacity");

  // The list does not change size while a search is running.
  a_search_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOP && op_r == OP_SEARCH) |=> $stable(cnt_r))
    else $error("count changed during a search");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine. A scoreboard class keeps
// its own copy of the list, works out the reply to every accepted request and
// compares each reply transaction with the oldest reply due. The stimulus runs
// directed corner cases first, then a steady stretch, output back-pressure, a
// fill to capacity, a drain to empty and random rounds with a growth, shrink or flat trend.
// ----------------------------------------------------------------------------
module tb_top;
  import plist_pkg::*;

  localparam int LIST_CAP    = DEFAULT_CAPACITY;
  localparam int POS_MAX     = (1 << POS_W) - 1;
  localparam int ITEM_TARGET = 1400;

  // Opcodes that the block must treat as no-ops.
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  typedef enum int {TREND_GROW, TREND_SHRINK, TREND_FLAT} list_trend_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [FPOS_W-1:0]       found_position;
    logic [LEN_W-1:0]        length;
    logic [STAT_W-1:0]       status;
  } list_reply_t;

  // Scoreboard: a shadow copy of the list plus the replies still owed.
  class list_scoreboard;
    logic [VAL_W-1:0] slots [LIST_CAP];
    int               fill;
    list_reply_t      replies_due [$];
    int unsigned      failures;
    int unsigned      results_seen;

    function new();
      fill = 0;
      failures = 0;
      results_seen = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    // Apply one request to the shadow list and return the reply it gives.
    function list_reply_t next_reply(input logic [OP_W-1:0] op,
                                     input logic [POS_W-1:0] pos,
                                     input logic [VAL_W-1:0] val);
      list_reply_t r;
      int          i;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_READ: begin
          if (pos < fill) r.read_value = slots[pos];
          else r.status = ST_BADPOS;
        end
        OP_WRITE: begin
          if (pos < fill) slots[pos] = val;
          else r.status = ST_BADPOS;
        end
        OP_INSERT: begin
          if (pos > fill) begin
            r.status = ST_BADPOS;
          end else if (fill >= LIST_CAP) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = val;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (pos < fill) begin
            r.read_value = slots[pos];
            for (i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end else begin
            r.status = ST_BADPOS;
          end
        end
        OP_SEARCH: begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < fill; i++) begin
            if (slots[i] == val) begin
              r.found_position = i[FPOS_W-1:0];
              r.status = ST_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      r.length = fill[LEN_W-1:0];
      return r;
    endfunction

    function void note_request(input logic [OP_W-1:0] op,
                               input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
      replies_due.push_back(next_reply(op, pos, val));
    endfunction

    function void flag(input string what, input logic [63:0] want_v,
                       input logic [63:0] got_v);
      failures++;
      if (failures <= 10)
        $display("[%0t] reply %0d: %s expected 0x%0h, got 0x%0h",
                 $time, results_seen, what, want_v, got_v);
    endfunction

    // Compare one reply transaction with the oldest reply due.
    function void check_result(input list_reply_t got);
      list_reply_t want;
      results_seen++;
      if (replies_due.size() == 0) begin
        flag("reply with no request outstanding", 64'd0, 64'(got));
        return;
      end
      want = replies_due.pop_front();
      if (got.read_value !== want.read_value)
        flag("read_value", 64'(want.read_value), 64'(got.read_value));
      if (got.found_position !== want.found_position)
        flag("found_position", 64'(want.found_position), 64'(got.found_position));
      if (got.length !== want.length)
        flag("length", 64'(want.length), 64'(got.length));
      if (got.status !== want.status)
        flag("status", 64'(want.status), 64'(got.status));
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function bit holds(input logic [VAL_W-1:0] val);
      for (int i = 0; i < fill; i++)
        if (slots[i] == val) return 1'b1;
      return 1'b0;
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op;
  logic [POS_W-1:0]        in_position;
  logic [VAL_W-1:0]        in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_read_value;
  logic [FPOS_W-1:0]       out_found_position;
  logic [LEN_W-1:0]        out_length;
  logic [STAT_W-1:0]       out_status;

  list_scoreboard tracker;
  bit             gaps_on = 1'b1;
  int             hold_off_cycles = 0;
  int             requests_sent = 0;

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_value    (out_read_value),
    .out_found_position(out_found_position),
    .out_length        (out_length),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Worst correct run is about 1400 requests, each walking up to CAPACITY entries,
  // plus stalls, roughly 5 ms; this limit allows several times that.
  initial begin
    #(30_000_000);
    $display("positional_list_engine verification failed");
    $finish;
  end

  // Reply side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 8);
      end
    end
  end

  // Every accepted reply transaction goes to the scoreboard.
  always @(posedge clk) begin : reply_monitor
    list_reply_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.read_value     = out_read_value;
      got.found_position = out_found_position;
      got.length         = out_length;
      got.status         = out_status;
      tracker.check_result(got);
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(op, pos, val);
    requests_sent++;
  endtask

  // Stop offering, then wait until every reply due has come back.
  task automatic wait_all_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Values cluster on a small set so that searches hit and find duplicates.
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 15) - 8;
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] absent_value();
    logic [VAL_W-1:0] v;
    do v = $urandom; while (tracker.holds(v));
    return v;
  endfunction

  // Mostly legal positions, with some just past the end and some anywhere.
  function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
    int top;
    int r;
    top = (op == OP_INSERT) ? tracker.fill : tracker.fill - 1;
    r = $urandom_range(0, 99);
    if (r < 8) return POS_W'($urandom_range(0, POS_MAX));
    if (r < 14) return POS_W'(top + 1);
    if (top < 0) return POS_W'($urandom_range(0, 3));
    return POS_W'($urandom_range(0, top));
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input list_trend_e trend);
    int r;
    int ins_w;
    int rem_w;
    ins_w = (trend == TREND_GROW) ? 45 : (trend == TREND_SHRINK) ? 10 : 25;
    rem_w = (trend == TREND_SHRINK) ? 45 : (trend == TREND_GROW) ? 10 : 25;
    r = $urandom_range(0, 99);
    if (r < ins_w) return OP_INSERT;
    r -= ins_w;
    if (r < rem_w) return OP_REMOVE;
    r -= rem_w;
    if (r < 15) return OP_READ;
    if (r < 27) return OP_WRITE;
    if (r < 100 - ins_w - rem_w - 3) return OP_SEARCH;
    case ($urandom_range(0, 2))
      0: return OP_SPARE_LO;
      1: return OP_SPARE_MID;
      default: return OP_SPARE_HI;
    endcase
  endfunction

  task automatic send_random(input list_trend_e trend);
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    op = pick_op(trend);
    if (op == OP_SEARCH || op == OP_SPARE_LO || op == OP_SPARE_MID || op == OP_SPARE_HI)
      pos = POS_W'($urandom_range(0, POS_MAX));
    else
      pos = pick_position(op);
    // Searches usually look for a value that is on the list.
    if (op == OP_SEARCH && tracker.fill > 0 && $urandom_range(0, 9) < 6)
      val = tracker.slots[$urandom_range(0, tracker.fill - 1)];
    else
      val = pick_value();
    send_request(op, pos, val);
  endtask

  initial begin
    list_trend_e      trend;
    logic [VAL_W-1:0] marker;
    int               waited;
    tracker     = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = OP_READ;
    in_position = '0;
    in_value    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list, then a short list with extreme and duplicate values.
    send_request(OP_READ,   9'd0,   32'h0000_0000);
    send_request(OP_WRITE,  9'd0,   32'h1111_1111);
    send_request(OP_REMOVE, 9'd0,   32'h0000_0000);
    send_request(OP_SEARCH, 9'd0,   32'h0000_0000);
    send_request(OP_INSERT, 9'd1,   32'h2222_2222);
    send_request(OP_INSERT, 9'd0,   32'h7FFF_FFFF);
    send_request(OP_INSERT, 9'd0,   32'h8000_0000);
    send_request(OP_INSERT, 9'd2,   32'hFFFF_FFFF);
    send_request(OP_INSERT, 9'd1,   32'h0000_0000);
    send_request(OP_INSERT, 9'd4,   32'h7FFF_FFFF);
    send_request(OP_READ,   9'd0,   32'h0000_0000);
    send_request(OP_READ,   9'd4,   32'h0000_0000);
    send_request(OP_READ,   9'd5,   32'h0000_0000);
    send_request(OP_READ,   9'h1FF, 32'h0000_0000);
    send_request(OP_WRITE,  9'h100, 32'h3333_3333);
    send_request(OP_WRITE,  9'd1,   32'h0000_0001);
    send_request(OP_SEARCH, 9'd0,   32'h7FFF_FFFF);
    send_request(OP_SEARCH, 9'h1FF, 32'h1234_5678);
    send_request(OP_REMOVE, 9'd5,   32'h0000_0000);
    send_request(OP_REMOVE, 9'd2,   32'h0000_0000);
    send_request(OP_REMOVE, 9'd0,   32'h0000_0000);
    send_request(OP_SPARE_LO,  9'h0AA, 32'hDEAD_BEEF);
    send_request(OP_SPARE_MID, 9'h155, 32'h5555_5555);
    send_request(OP_SPARE_HI,  9'h1FF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 9'h1FF, 32'h4444_4444);

    // Steady stretch with no idling on either side.
    gaps_on = 1'b0;
    repeat (150) send_random(TREND_FLAT);

    // Long reply hold-off while requests keep coming, so the input backs up.
    wait_all_replies();
    @(posedge clk);
    hold_off_cycles = 90;
    repeat (12) send_random(TREND_FLAT);
    gaps_on = 1'b1;
    wait_all_replies();

    // Fill the list to capacity, mostly by appending.
    while (tracker.fill < LIST_CAP) begin
      if ($urandom_range(0, 9) == 0)
        send_random(TREND_FLAT);
      else if ($urandom_range(0, 9) < 7)
        send_request(OP_INSERT, POS_W'(tracker.fill), pick_value());
      else
        send_request(OP_INSERT, POS_W'($urandom_range(0, tracker.fill)), pick_value());
    end

    // Full list: refused inserts, a full-length miss and a hit in the last slot.
    send_request(OP_INSERT, 9'd0, pick_value());
    send_request(OP_INSERT, POS_W'(LIST_CAP), pick_value());
    send_request(OP_INSERT, POS_W'(LIST_CAP + 1), pick_value());
    send_request(OP_INSERT, 9'h1FF, pick_value());
    send_request(OP_SEARCH, POS_W'($urandom_range(0, POS_MAX)), absent_value());
    marker = absent_value();
    send_request(OP_WRITE, POS_W'(LIST_CAP - 1), marker);
    send_request(OP_SEARCH, POS_W'($urandom_range(0, POS_MAX)), marker);
    send_request(OP_READ, POS_W'(LIST_CAP - 1), 32'h0000_0000);
    send_request(OP_REMOVE, POS_W'(LIST_CAP - 1), 32'h0000_0000);

    // Drain the list back to empty.
    while (tracker.fill > 0) begin
      if ($urandom_range(0, 99) < 15)
        send_random(TREND_FLAT);
      else
        send_request(OP_REMOVE, POS_W'($urandom_range(0, tracker.fill - 1)),
                     pick_value());
    end
    wait_all_replies();

    // Random rounds; the trend keeps the length moving across its range.
    while (requests_sent < ITEM_TARGET) begin
      if (tracker.fill < 20) trend = TREND_GROW;
      else if (tracker.fill > LIST_CAP - 26) trend = TREND_SHRINK;
      else trend = list_trend_e'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 5) != 0);
      repeat ($urandom_range(20, 60)) send_random(trend);
      if ($urandom_range(0, 3) == 0) wait_all_replies();
    end

    // Let the last replies drain, then allow one worst-case request time.
    @(negedge clk);
    in_valid <= 1'b0;
    gaps_on = 1'b0;
    waited = 0;
    while (tracker.pending() != 0 && waited < 50_000) begin
      @(negedge clk);
      waited++;
    end
    repeat (LIST_CAP + 16) @(posedge clk);
    while (tracker.pending() != 0) begin
      tracker.flag("reply never arrived", 64'(tracker.replies_due[0]), 64'd0);
      void'(tracker.replies_due.pop_front());
    end

    if (tracker.failures == 0)
      $display("positional_list_engine verification clean");
    else
      $display("positional_list_engine verification failed");
    $finish;
  end

endmodule

>>> files.f
src/plist_pkg.sv
src/plist_ram.sv
src/positional_list_engine.sv
sim/tb_top.sv
